/* hdl/khss_pkg.sv */
// Shared types and constants for the key hash server selector.
`default_nettype none
package khss_pkg;

    localparam int SERVER_LIMIT = 16;
    localparam int SLOT_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int HASH_W       = 32;

    localparam logic [31:0] CRC_POLY     = 32'hedb88320;
    localparam logic [31:0] CRC_INIT     = 32'hffffffff;
    localparam int          DEFAULT_LSB  = 16;
    localparam int          DEFAULT_BITS = 15;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_LIVE = 2'd1;
    localparam logic [1:0] CMD_DEAD = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SERVER_COUNT = 1'b0;
    localparam logic CFG_HASH_MODE    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_PROBE = 4'b0100,
        ST_HOLD  = 4'b1000
    } khss_state_t;

    // Status of the iterative remainder unit.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SLOT_W-1:0] remainder;
    } khss_mod_status_t;

endpackage
`default_nettype wire

/* hdl/key_hash_server_selector_unit.sv */
// Top level of the key hash server selector: stream ports, sequencer and probe.
`default_nettype none
// Key bytes arrive one per input transaction and are folded into a reflected
// CRC-32 in the same cycle, so a key streams in at one byte per clock. The
// final byte (tlast) starts the lookup: the hash (crc bits 30..16, or the
// whole crc in full mode; zero is taken as one) is reduced modulo the server
// count by a bit-serial remainder unit, which takes 32 bit steps and then
// hands the remainder over. Servers are then probed one per cycle from that
// slot upward with wrap, up to server_count servers, and the result is then
// moved into the output register. A final byte thus keeps the input not
// ready through the division and probing, and longer while the output
// register is still occupied; a count of zero skips the division and probing.
// Mark-live and mark-dead commands may arrive while a result still waits on
// the output. Configuration writes are always ready and should be made only
// while no lookup is in flight. No result is produced for plain key bytes,
// for live or dead marks, or for the unused command code.
module key_hash_server_selector_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // key_byte[7:0], server_index[11:8], zero fill
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    input  wire logic        s_axis_tlast,   // last_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // chosen_server[3:0], hash_value[35:4], zero fill
    output logic      [0:0]  m_axis_tuser,   // found[0]

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    localparam int SW = khss_pkg::SLOT_W;
    localparam int CW = khss_pkg::COUNT_W;
    localparam int HW = khss_pkg::HASH_W;

    khss_pkg::khss_state_t state_reg, state_next;

    logic [CW-1:0]                     server_count_reg;
    logic                              hash_mode_reg;
    logic [khss_pkg::SERVER_LIMIT-1:0] live_reg, live_next;

    logic [HW-1:0] hash_reg, hash_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] tried_reg, tried_next;
    logic          res_found_reg, res_found_next;
    logic [SW-1:0] res_slot_reg, res_slot_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_found_reg;
    logic [SW-1:0] out_slot_reg;
    logic [HW-1:0] out_hash_reg;
    logic          out_load;

    logic [7:0]    key_byte;
    logic [SW-1:0] server_index;
    logic [1:0]    cmd;
    logic          in_accept;
    logic          key_accept;
    logic          lookup_start;

    logic [HW-1:0] crc_final;
    logic [HW-1:0] hash_now;
    logic [HW-1:0] probe_key;
    logic [CW-1:0] eff_count;
    logic          mod_start;
    logic [CW-1:0] slot_inc;

    khss_pkg::khss_mod_status_t mod_status;

    assign key_byte     = s_axis_tdata[7:0];
    assign server_index = s_axis_tdata[11:8];
    assign cmd          = s_axis_tuser;

    assign s_axis_tready = (state_reg == khss_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign key_accept    = in_accept && (cmd == khss_pkg::CMD_KEY);
    assign lookup_start  = key_accept && s_axis_tlast;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg <= '0;
            hash_mode_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                khss_pkg::CFG_SERVER_COUNT: server_count_reg <= cfg_data;
                khss_pkg::CFG_HASH_MODE:    hash_mode_reg    <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    khss_crc_unit u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (key_accept),
        .restart   (s_axis_tlast),
        .key_byte  (key_byte),
        .crc_final (crc_final)
    );

    // The mode is sampled with the final byte.
    assign hash_now  = hash_mode_reg ? crc_final
                     : {{(HW - khss_pkg::DEFAULT_BITS){1'b0}},
                        crc_final[khss_pkg::DEFAULT_LSB +: khss_pkg::DEFAULT_BITS]};
    assign probe_key = (hash_now == '0) ? HW'(1) : hash_now;

    // Counts above the number of nameable servers saturate.
    assign eff_count = (server_count_reg > CW'(khss_pkg::SERVER_LIMIT))
                     ? CW'(khss_pkg::SERVER_LIMIT) : server_count_reg;

    assign mod_start = lookup_start && (eff_count != '0);

    khss_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (probe_key),
        .divisor  (eff_count),
        .status   (mod_status)
    );

    assign slot_inc = {1'b0, slot_reg} + CW'(1);

    // Sequencer: marks while idle, division, then one probe per cycle, then hand-off (a zero count skips to hand-off).
    always_comb
    begin
        state_next     = state_reg;
        live_next      = live_reg;
        hash_next      = hash_reg;
        n_next         = n_reg;
        slot_next      = slot_reg;
        tried_next     = tried_reg;
        res_found_next = res_found_reg;
        res_slot_next  = res_slot_reg;
        out_load       = 1'b0;

        case (state_reg)
            khss_pkg::ST_IDLE:
            begin
                if (in_accept && (cmd == khss_pkg::CMD_LIVE || cmd == khss_pkg::CMD_DEAD))
                begin
                    live_next[server_index] = (cmd == khss_pkg::CMD_LIVE);
                end
                if (lookup_start)
                begin
                    hash_next      = hash_now;
                    n_next         = eff_count;
                    res_found_next = 1'b0;
                    res_slot_next  = '0;
                    state_next     = (eff_count == '0) ? khss_pkg::ST_HOLD
                                                       : khss_pkg::ST_DIV;
                end
            end
            khss_pkg::ST_DIV:
            begin
                if (mod_status.done)
                begin
                    slot_next  = mod_status.remainder;
                    tried_next = '0;
                    state_next = khss_pkg::ST_PROBE;
                end
            end
            khss_pkg::ST_PROBE:
            begin
                if (live_reg[slot_reg])
                begin
                    res_found_next = 1'b1;
                    res_slot_next  = slot_reg;
                    state_next     = khss_pkg::ST_HOLD;
                end
                else
                begin
                    tried_next = tried_reg + CW'(1);
                    slot_next  = (slot_inc == n_reg) ? '0 : slot_inc[SW-1:0];
                    if (tried_reg + CW'(1) == n_reg)
                    begin
                        state_next = khss_pkg::ST_HOLD;
                    end
                end
            end
            khss_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = khss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = khss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= khss_pkg::ST_IDLE;
            live_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg      <= hash_next;
        n_reg         <= n_next;
        slot_reg      <= slot_next;
        tried_reg     <= tried_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
        if (out_load)
        begin
            out_found_reg <= res_found_reg;
            out_slot_reg  <= res_slot_reg;
            out_hash_reg  <= hash_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_hash_reg, out_slot_reg};
    assign m_axis_tuser  = out_found_reg;

    // The remainder unit only runs while the sequencer waits on it.
    a_mod_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        mod_status.busy |-> (state_reg == khss_pkg::ST_DIV))
        else $error("remainder unit busy outside the division phase");

    // Probing never looks past the active server count.
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == khss_pkg::ST_PROBE) |-> ({1'b0, slot_reg} < n_reg && tried_reg < n_reg))
        else $error("probe slot or try count out of range");

    // A finished lookup waits while the output register is still occupied.
    a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == khss_pkg::ST_HOLD && out_valid_reg && !m_axis_tready)
        |=> (state_reg == khss_pkg::ST_HOLD && out_valid_reg))
        else $error("result overwrote a pending output transaction");

endmodule
`default_nettype wire

/* hdl/khss_crc_unit.sv */
// CRC-32 accumulator that folds in one key byte per transaction.
`default_nettype none
module khss_crc_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        update,
    input  wire logic        restart,
    input  wire logic [7:0]  key_byte,
    output logic      [31:0] crc_final
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] crc_step;

    // Eight bit steps of the reflected CRC on one byte.
    always_comb
    begin
        logic [31:0] c;
        c = acc_reg ^ {24'b0, key_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ khss_pkg::CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_step = c;
    end

    assign crc_final = ~crc_step;

    always_comb
    begin
        acc_next = acc_reg;
        if (update)
        begin
            acc_next = restart ? khss_pkg::CRC_INIT : crc_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= khss_pkg::CRC_INIT;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/khss_mod_unit.sv */
// Bit-serial remainder unit: 32-bit dividend modulo a count of 1 to 16.
`default_nettype none
module khss_mod_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [khss_pkg::HASH_W-1:0]  dividend,
    input  wire logic [khss_pkg::COUNT_W-1:0] divisor,
    output khss_pkg::khss_mod_status_t        status
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic [khss_pkg::HASH_W-1:0]  quo_reg, quo_next;
    logic [khss_pkg::SLOT_W-1:0]  rem_reg, rem_next;
    logic [khss_pkg::COUNT_W-1:0] div_reg, div_next;
    logic [khss_pkg::COUNT_W-1:0] trial;

    // The remainder stays below the divisor, so one shifted-in bit
    // needs at most one subtraction.
    assign trial = {rem_reg, quo_reg[khss_pkg::HASH_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(khss_pkg::HASH_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            if (trial >= div_reg)
            begin
                rem_next = khss_pkg::SLOT_W'(trial - div_reg);
            end
            else
            begin
                rem_next = khss_pkg::SLOT_W'(trial);
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign status.busy      = busy_reg;
    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

endmodule
`default_nettype wire

/* dv/tb_key_hash_server_selector_unit.sv */
// Self-checking testbench for the key hash server selector top level.
`default_nettype none
module tb_key_hash_server_selector_unit;
    import khss_pkg::*;

    // The block defines no name for the spare command code, so the bench names it here.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // This many quiet cycles after the last result cover anything still moving
    // inside the block.
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_MAX      = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;

    // One lookup result as the output stream carries it.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] chosen;
        logic [HASH_W-1:0] hash;
    } lookup_t;

    // Holds a private copy of the CRC, the live map and both registers. Every
    // accepted input transaction is folded in, and each final key byte leaves
    // one predicted lookup in a queue that the output side drains in order.
    class selector_scoreboard;
        logic [COUNT_W-1:0] count_q;
        logic               mode_q;
        logic [31:0]        acc_q;
        bit                 live_q [SERVER_LIMIT];
        lookup_t            lookup_q [$];
        int                 errors;

        function new();
            count_q = '0;
            mode_q  = 1'b0;
            acc_q   = CRC_INIT;
            errors  = 0;
            foreach (live_q[i]) live_q[i] = 1'b1;
        endfunction

        // Reflected CRC-32 over one byte, least significant bit first.
        static function logic [31:0] fold_byte(logic [31:0] crc, logic [7:0] data);
            logic [31:0] c;
            c = crc ^ {24'd0, data};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void write_reg(logic idx, logic [COUNT_W-1:0] data);
            if (idx == CFG_SERVER_COUNT)
                count_q = data;
            else
                mode_q = data[0];
        endfunction

        function int pending();
            return lookup_q.size();
        endfunction

        function void note_input(logic [1:0] cmd, logic [7:0] key, logic last,
                                 logic [SLOT_W-1:0] sidx);
            logic [31:0] crc;
            logic [31:0] hash;
            logic [31:0] h;
            int unsigned n;
            int unsigned slot;
            lookup_t     r;
            if (cmd == CMD_LIVE || cmd == CMD_DEAD)
            begin
                if (sidx < SERVER_LIMIT)
                    live_q[sidx] = (cmd == CMD_LIVE);
                return;
            end
            if (cmd != CMD_KEY)
                return;
            acc_q = fold_byte(acc_q, key);
            if (!last)
                return;
            crc   = ~acc_q;
            acc_q = CRC_INIT;
            hash  = mode_q ? crc : {17'd0, crc[DEFAULT_LSB +: DEFAULT_BITS]};
            h     = (hash == 0) ? 32'd1 : hash;
            n     = (count_q > SERVER_LIMIT) ? SERVER_LIMIT : count_q;
            r.found  = 1'b0;
            r.chosen = '0;
            r.hash   = hash;
            for (int unsigned i = 0; i < n; i++)
            begin
                slot = ((h % n) + i) % n;
                if (live_q[slot])
                begin
                    r.found  = 1'b1;
                    r.chosen = slot[SLOT_W-1:0];
                    break;
                end
            end
            lookup_q.push_back(r);
        endfunction

        function void check_result(logic found, logic [SLOT_W-1:0] chosen,
                                   logic [HASH_W-1:0] hash);
            lookup_t e;
            if (lookup_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual found %0d server %0d hash %h",
                         $time, found, chosen, hash);
                errors++;
                return;
            end
            e = lookup_q.pop_front();
            if (found !== e.found)
            begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, e.found, found);
                errors++;
            end
            if (chosen !== e.chosen)
            begin
                $display("%0t: chosen_server mismatch, expected %0d, actual %0d",
                         $time, e.chosen, chosen);
                errors++;
            end
            if (hash !== e.hash)
            begin
                $display("%0t: hash_value mismatch, expected %h, actual %h",
                         $time, e.hash, hash);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index     = '0;
    logic [4:0]  cfg_data      = '0;

    // When cleared, both sides run back to back with no idle cycles.
    bit idle_on = 1'b1;

    selector_scoreboard sb = new();

    key_hash_server_selector_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs. The slowest legal run is far shorter.
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // Drives one input transaction. All signals change on a rising edge; the
    // handshake is sampled on the falling edge before the edge that takes it,
    // so nothing depends on event order inside a time step. The valid stays
    // high after the transaction so that back-to-back items never glitch it.
    task automatic send_item(logic [1:0] cmd, logic [7:0] key, logic last,
                             logic [SLOT_W-1:0] sidx);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, sidx, key};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        sb.note_input(cmd, key, last, sidx);
    endtask

    // A key of the given length with random bytes; only the final byte has tlast.
    task automatic send_key(int len);
        for (int i = 0; i < len; i++)
            send_item(CMD_KEY, 8'($urandom), (i == len - 1), 4'($urandom));
    endtask

    // Sender pause: wait for every outstanding result, then let the block settle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One configuration transaction. The extra edge keeps two writes in a row
    // from lowering and raising cfg_valid in the same time step.
    task automatic write_cfg(logic idx, logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Hash mode writes put random values in the unused upper data bits.
    task automatic set_mode(logic mode);
        write_cfg(CFG_HASH_MODE, {4'($urandom), mode});
    endtask

    // Output side: stalls a random number of cycles per result, then accepts it.
    // Each pass starts at the edge that took the previous transaction, so tready
    // is never left high over an edge that nobody samples.
    initial
    begin
        int          stall;
        logic        found;
        logic [3:0]  chosen;
        logic [31:0] hash;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge clk); while (m_axis_tvalid !== 1'b1);
            found  = m_axis_tuser[0];
            chosen = m_axis_tdata[3:0];
            hash   = m_axis_tdata[35:4];
            @(posedge clk);
            sb.check_result(found, chosen, hash);
        end
    end

    initial
    begin
        logic [7:0]  zero_key [3];
        bit          have_zero_key;
        logic [31:0] crc_a;
        logic [31:0] crc_b;
        logic [31:0] crc_c;
        int          items;
        int          pick;
        int          len;
        logic [4:0]  count_pick;

        // Look for a three-byte key whose default-mode hash is zero, so that the
        // zero-becomes-one rule for the probe start can be exercised on purpose.
        have_zero_key = 1'b0;
        for (int a = 0; a < 256 && !have_zero_key; a++)
        begin
            crc_a = selector_scoreboard::fold_byte(CRC_INIT, 8'(a));
            for (int b = 0; b < 256 && !have_zero_key; b++)
            begin
                crc_b = selector_scoreboard::fold_byte(crc_a, 8'(b));
                for (int c = 0; c < 256 && !have_zero_key; c++)
                begin
                    crc_c = ~selector_scoreboard::fold_byte(crc_b, 8'(c));
                    if (crc_c[DEFAULT_LSB +: DEFAULT_BITS] == 0)
                    begin
                        zero_key[0]   = 8'(a);
                        zero_key[1]   = 8'(b);
                        zero_key[2]   = 8'(c);
                        have_zero_key = 1'b1;
                    end
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reset leaves a count of zero: found stays low but the
        // hash is still reported. The spare command code must do nothing.
        send_item(CMD_KEY, 8'h00, 1'b1, 4'hf);
        send_item(CMD_UNUSED, 8'hff, 1'b1, 4'hf);
        settle();

        write_cfg(CFG_SERVER_COUNT, 5'd16);
        set_mode(1'b0);
        send_item(CMD_KEY, 8'hff, 1'b1, 4'h0);
        if (have_zero_key)
            for (int i = 0; i < 3; i++)
                send_item(CMD_KEY, zero_key[i], (i == 2), 4'h0);
        settle();

        set_mode(1'b1);
        send_item(CMD_KEY, 8'h00, 1'b0, 4'h0);
        send_item(CMD_KEY, 8'hff, 1'b1, 4'hf);
        // Dead marks at both ends of the index range shift the chosen server.
        send_item(CMD_DEAD, 8'hff, 1'b0, 4'h0);
        send_item(CMD_DEAD, 8'h00, 1'b1, 4'hf);
        send_item(CMD_KEY, 8'h5a, 1'b1, 4'h3);
        settle();

        // Two servers, both dead: nothing can be found.
        write_cfg(CFG_SERVER_COUNT, 5'd2);
        send_item(CMD_DEAD, 8'h00, 1'b0, 4'h1);
        send_item(CMD_KEY, 8'ha5, 1'b1, 4'h0);
        send_item(CMD_LIVE, 8'h00, 1'b0, 4'h1);
        settle();

        // Counts above sixteen saturate; a count of one always probes slot zero.
        write_cfg(CFG_SERVER_COUNT, 5'd31);
        send_item(CMD_KEY, 8'h3c, 1'b1, 4'h0);
        settle();
        write_cfg(CFG_SERVER_COUNT, 5'd1);
        send_item(CMD_KEY, 8'hc3, 1'b1, 4'h0);
        settle();

        // The mode is only read at the final byte, so a change mid key counts.
        write_cfg(CFG_SERVER_COUNT, 5'd3);
        send_item(CMD_KEY, 8'h12, 1'b0, 4'h0);
        settle();
        set_mode(1'b0);
        send_item(CMD_KEY, 8'h34, 1'b1, 4'h0);
        // With all three servers live, a zero hash must start the probe at one.
        send_item(CMD_LIVE, 8'h00, 1'b0, 4'h0);
        send_item(CMD_LIVE, 8'h00, 1'b0, 4'hf);
        if (have_zero_key)
            for (int i = 0; i < 3; i++)
                send_item(CMD_KEY, zero_key[i], (i == 2), 4'h0);
        settle();

        // Random part: mostly complete keys, with live and dead marks in
        // between and some noise. Each phase uses its own register setting,
        // written only after the block has gone quiet.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count_pick = 5'd16;
                1:       count_pick = 5'd1;
                2:       count_pick = 5'd0;
                3:       count_pick = 5'd31;
                default: count_pick = 5'($urandom_range(0, 31));
            endcase
            write_cfg(CFG_SERVER_COUNT, count_pick);
            set_mode((p < 4) ? p[0] : 1'($urandom));
            idle_on = (p != 5);
            items   = 0;
            while (items < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                      : $urandom_range(1, 4);
                    send_key(len);
                    items += len;
                end
                else if (pick < 70)
                begin
                    // A broken key: bytes without tlast that run into the next key.
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        send_item(CMD_KEY, 8'($urandom), 1'b0, 4'($urandom));
                    items += len;
                end
                else if (pick < 93)
                begin
                    send_item((pick < 80) ? CMD_LIVE : CMD_DEAD, 8'($urandom),
                              1'($urandom), 4'($urandom));
                    items++;
                end
                else
                begin
                    send_item(CMD_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom));
                end
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
